// File: design/ams_pkg.sv
// ams_pkg: shared types, constants and helpers for the attitude mode supervisor
// used by every design file of the block; depends on nothing

package ams_pkg;

   localparam int AMS_QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_SAFE_RATE_LIMIT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETUMBLE_RATE_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTITUDE_ERR_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACQUISITION_TIMEOUT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINTING_GUARD      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUMP_TRIGGER        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUMP_COMPLETE       = 3'd6;

   // output mode codes
   localparam logic [2:0] MODE_SAFE       = 3'd0;
   localparam logic [2:0] MODE_DETUMBLING = 3'd1;
   localparam logic [2:0] MODE_SUN_ACQ    = 3'd2;
   localparam logic [2:0] MODE_FINE       = 3'd3;
   localparam logic [2:0] MODE_DUMP       = 3'd4;

   localparam logic [2:0] RECOVERY_FACTOR = 3'd5;

   typedef enum logic [4:0] {
      ST_SAFE     = 5'b00001,
      ST_DETUMBLE = 5'b00010,
      ST_SUN_ACQ  = 5'b00100,
      ST_FINE     = 5'b01000,
      ST_DUMP     = 5'b10000
   } state_type;

   typedef struct packed {
      logic [31:0]        time_ms;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
      logic signed [15:0] momentum_x;
      logic signed [15:0] momentum_y;
      logic signed [15:0] momentum_z;
      logic               attitude_err_valid;
      logic [15:0]        attitude_err;
      logic               external_fault;
      logic               pointing_err_fresh;
      logic [15:0]        pointing_err;
   } req_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] previous_mode;
      logic [1:0] fault_bits;
      logic       mode_changed;
   } rsp_type;

   // configuration as seen by the datapath, rate limits already squared
   typedef struct packed {
      logic [29:0] safe_sq;
      logic [29:0] detumble_sq;
      logic [34:0] recovery_sq;
      logic [15:0] attitude_err_limit;
      logic [31:0] acquisition_timeout;
      logic [15:0] pointing_guard;
      logic [14:0] dump_trigger;
      logic [14:0] dump_complete;
   } cfg_type;

   // classified tick, handed from front to back
   typedef struct packed {
      logic [31:0] time_ms;
      logic        rate_over;
      logic        rate_recovered;
      logic        rate_settled;
      logic        momentum_high;
      logic        momentum_low;
      logic        external_fault;
      logic        attitude_err_valid;
      logic [15:0] attitude_err;
      logic        pointing_err_fresh;
      logic [15:0] pointing_err;
   } cls_type;

   function automatic logic [15:0] abs16(input logic signed [15:0] v);
      abs16 = v[15] ? 16'(-v) : 16'(v);
   endfunction

   function automatic logic [2:0] mode_code(input state_type s);
      case (s)
         ST_SAFE:     mode_code = MODE_SAFE;
         ST_DETUMBLE: mode_code = MODE_DETUMBLING;
         ST_SUN_ACQ:  mode_code = MODE_SUN_ACQ;
         ST_FINE:     mode_code = MODE_FINE;
         ST_DUMP:     mode_code = MODE_DUMP;
         default:     mode_code = MODE_SAFE;
      endcase
   endfunction

endpackage

// File: design/ams_front.sv
// ams_front: classifies one tick against the squared rate limits and momentum limits
// depends on ams_pkg

module ams_front (
   input  ams_pkg::req_type req,
   input  ams_pkg::cfg_type cfg,
   output ams_pkg::cls_type cls
);
   import ams_pkg::*;

   logic [15:0] ax, ay, az;
   logic [31:0] sq_x, sq_y, sq_z;
   logic [31:0] rate_sq;
   logic [15:0] hx, hy, hz, h_max;

   always_comb begin
      ax = abs16(req.rate_x);
      ay = abs16(req.rate_y);
      az = abs16(req.rate_z);
      sq_x = 32'(ax) * 32'(ax);
      sq_y = 32'(ay) * 32'(ay);
      sq_z = 32'(az) * 32'(az);
      // three squares of at most 2^30 each stay below 2^32
      rate_sq = sq_x + sq_y + sq_z;

      hx = abs16(req.momentum_x);
      hy = abs16(req.momentum_y);
      hz = abs16(req.momentum_z);
      h_max = hx;
      if (hy > h_max) begin
         h_max = hy;
      end
      if (hz > h_max) begin
         h_max = hz;
      end

      cls.time_ms            = req.time_ms;
      cls.rate_over          = rate_sq > {2'b00, cfg.safe_sq};
      cls.rate_recovered     = {3'b000, rate_sq} < cfg.recovery_sq;
      cls.rate_settled       = rate_sq < {2'b00, cfg.detumble_sq};
      cls.momentum_high      = h_max > {1'b0, cfg.dump_trigger};
      cls.momentum_low       = h_max < {1'b0, cfg.dump_complete};
      cls.external_fault     = req.external_fault;
      cls.attitude_err_valid = req.attitude_err_valid;
      cls.attitude_err       = req.attitude_err;
      cls.pointing_err_fresh = req.pointing_err_fresh;
      cls.pointing_err       = req.pointing_err;
   end

endmodule

// File: design/ams_queue.sv
// ams_queue: small fifo of classified ticks between front and back
// depends on ams_pkg

module ams_queue #(
   parameter int DEPTH = ams_pkg::AMS_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ams_pkg::cls_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output ams_pkg::cls_type out_data
);
   import ams_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cls_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: design/ams_back.sv
// ams_back: mode state machine, latched errors and the result register
// depends on ams_pkg

module ams_back (
   input  logic             clock,
   input  logic             reset,
   input  ams_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  ams_pkg::cls_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ams_pkg::rsp_type rsp_data
);
   import ams_pkg::*;

   state_type   state_ff, state_in;
   logic [2:0]  last_mode_ff, last_mode_in;
   logic [31:0] entry_time_ff, entry_time_in;
   logic [1:0]  sticky_ff, sticky_in;
   logic        att_seen_ff, att_seen_in;
   logic [15:0] att_latched_ff, att_latched_in;
   logic        pt_seen_ff, pt_seen_in;
   logic [15:0] pt_latched_ff, pt_latched_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        pop;

   assign in_ready  = !rsp_valid_ff || rsp_ready;
   assign pop       = in_valid && in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_type   target;
      logic [31:0] in_mode;
      logic        att_ok;
      logic        pt_ok;
      logic        changed;

      state_in       = state_ff;
      last_mode_in   = last_mode_ff;
      entry_time_in  = entry_time_ff;
      sticky_in      = sticky_ff;
      att_seen_in    = att_seen_ff;
      att_latched_in = att_latched_ff;
      pt_seen_in     = pt_seen_ff;
      pt_latched_in  = pt_latched_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      target         = state_ff;
      in_mode        = in_data.time_ms - entry_time_ff;
      att_ok         = 1'b0;
      pt_ok          = 1'b0;
      changed        = 1'b0;

      if (pop) begin
         // pointing error is latched in every mode, ahead of the tests
         if (in_data.pointing_err_fresh) begin
            pt_seen_in    = 1'b1;
            pt_latched_in = in_data.pointing_err;
         end

         if (in_data.external_fault || in_data.rate_over) begin
            sticky_in = sticky_ff | {in_data.external_fault, in_data.rate_over};
            target    = ST_SAFE;
         end else begin
            case (state_ff)
               ST_SAFE: begin
                  if (in_data.rate_recovered) begin
                     sticky_in = '0;
                     target    = ST_DETUMBLE;
                  end
               end
               ST_DETUMBLE: begin
                  if (in_data.rate_settled) begin
                     target = ST_SUN_ACQ;
                  end
               end
               ST_SUN_ACQ: begin
                  // attitude error only latched while acquiring
                  if (in_data.attitude_err_valid) begin
                     att_seen_in    = 1'b1;
                     att_latched_in = in_data.attitude_err;
                  end
                  att_ok = att_seen_in && (att_latched_in < cfg.attitude_err_limit);
                  if (att_ok || (in_mode > cfg.acquisition_timeout)) begin
                     target = ST_FINE;
                  end
               end
               ST_FINE: begin
                  pt_ok = !pt_seen_in || (pt_latched_in < cfg.pointing_guard);
                  if (in_data.momentum_high && pt_ok) begin
                     target = ST_DUMP;
                  end
               end
               ST_DUMP: begin
                  if (in_data.momentum_low) begin
                     target = ST_FINE;
                  end
               end
               default: begin
                  target = ST_SAFE;
               end
            endcase
         end

         changed = target != state_ff;
         if (changed) begin
            last_mode_in  = mode_code(state_ff);
            state_in      = target;
            entry_time_in = in_data.time_ms;
         end

         rsp_valid_in              = 1'b1;
         rsp_data_in.mode          = mode_code(state_in);
         rsp_data_in.previous_mode = last_mode_in;
         rsp_data_in.fault_bits    = sticky_in;
         rsp_data_in.mode_changed  = changed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_DETUMBLE;
         last_mode_ff   <= MODE_DETUMBLING;
         entry_time_ff  <= '0;
         sticky_ff      <= '0;
         att_seen_ff    <= 1'b0;
         att_latched_ff <= '0;
         pt_seen_ff     <= 1'b0;
         pt_latched_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_mode_ff   <= last_mode_in;
         entry_time_ff  <= entry_time_in;
         sticky_ff      <= sticky_in;
         att_seen_ff    <= att_seen_in;
         att_latched_ff <= att_latched_in;
         pt_seen_ff     <= pt_seen_in;
         pt_latched_ff  <= pt_latched_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: design/attitude_mode_supervisor.sv
// attitude_mode_supervisor: top level, configuration registers, front, queue and back
// depends on ams_pkg, ams_front, ams_queue, ams_back

// Five-mode attitude supervisor (safe, detumble, sun acquisition, fine pointing,
// momentum dump). Each tick transfer on the req_ channel yields exactly one result
// transfer on the rsp_ channel, in order. The block takes one tick per clock
// cycle while the queue has room; the front classifier squares the three body
// rates, sums them and compares against the squared limits combinationally. A
// result is registered in the queue by the front, then in the result register by
// the back's mode update. The queue of QUEUE_DEPTH ticks lets req_ keep flowing
// for that many ticks while rsp_ is stalled. Configuration registers are written
// through the csr_ port, always ready; their squared forms are formed at write
// time, so a tick may follow a write in the next cycle. Writes must happen only
// while no tick is in flight. Indexes beyond the register list are ignored.

module attitude_mode_supervisor #(
   parameter int QUEUE_DEPTH = ams_pkg::AMS_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ams_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ams_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ams_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ams_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ams_pkg::*;

   // configuration, limits kept squared for the rate tests
   logic [29:0] safe_sq_ff;
   logic [29:0] detumble_sq_ff;
   logic [34:0] recovery_sq_ff;
   logic [15:0] attitude_err_limit_ff;
   logic [31:0] acquisition_timeout_ff;
   logic [15:0] pointing_guard_ff;
   logic [14:0] dump_trigger_ff;
   logic [14:0] dump_complete_ff;

   logic        csr_write;
   logic [14:0] csr_low15;
   logic [29:0] csr_sq;
   logic [34:0] recovery_sq;
   cfg_type     cfg;
   cls_type     front_cls;
   cls_type     queue_head;
   logic        queue_valid;
   logic        back_ready;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_low15 = csr_data[14:0];
   assign csr_sq    = 30'(csr_low15) * 30'(csr_low15);
   // five times the detumble limit, squared: 25 times its square, 16 + 8 + 1
   assign recovery_sq = {1'b0, csr_sq, 4'b0000} + {2'b00, csr_sq, 3'b000}
                      + {5'b00000, csr_sq};

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_sq_ff             <= '0;
         detumble_sq_ff         <= '0;
         recovery_sq_ff         <= '0;
         attitude_err_limit_ff  <= '0;
         acquisition_timeout_ff <= '0;
         pointing_guard_ff      <= '0;
         dump_trigger_ff        <= '0;
         dump_complete_ff       <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SAFE_RATE_LIMIT: begin
               safe_sq_ff <= csr_sq;
            end
            CSR_DETUMBLE_RATE_LIMIT: begin
               detumble_sq_ff <= csr_sq;
               recovery_sq_ff <= recovery_sq;
            end
            CSR_ATTITUDE_ERR_LIMIT: begin
               attitude_err_limit_ff <= csr_data[15:0];
            end
            CSR_ACQUISITION_TIMEOUT: begin
               acquisition_timeout_ff <= csr_data;
            end
            CSR_POINTING_GUARD: begin
               pointing_guard_ff <= csr_data[15:0];
            end
            CSR_DUMP_TRIGGER: begin
               dump_trigger_ff <= csr_low15;
            end
            CSR_DUMP_COMPLETE: begin
               dump_complete_ff <= csr_low15;
            end
            default: begin
               // index beyond the register list, nothing written
            end
         endcase
      end
   end

   always_comb begin
      cfg.safe_sq             = safe_sq_ff;
      cfg.detumble_sq         = detumble_sq_ff;
      cfg.recovery_sq         = recovery_sq_ff;
      cfg.attitude_err_limit  = attitude_err_limit_ff;
      cfg.acquisition_timeout = acquisition_timeout_ff;
      cfg.pointing_guard      = pointing_guard_ff;
      cfg.dump_trigger        = dump_trigger_ff;
      cfg.dump_complete       = dump_complete_ff;
   end

   // front: rate and momentum classification of the incoming tick
   ams_front u_front (
      .req (req_data),
      .cfg (cfg),
      .cls (front_cls)
   );

   // queue: decouples tick intake from the mode update
   ams_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (front_cls),
      .out_valid (queue_valid),
      .out_ready (back_ready),
      .out_data  (queue_head)
   );

   // back: mode state machine and result register
   ams_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (queue_valid),
      .in_ready  (back_ready),
      .in_data   (queue_head),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a reported transition always moves to a different mode
   a_changed_differs : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mode_changed |-> rsp_data.mode != rsp_data.previous_mode)
      else $error("mode_changed set without a mode difference");

   // entering safe mode always leaves a fault reason behind
   a_safe_entry_fault : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mode_changed && rsp_data.mode == MODE_SAFE
         |-> rsp_data.fault_bits != 2'b00)
      else $error("safe mode entered with no fault recorded");

   // sticky faults only survive while in safe mode
   a_faults_only_in_safe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault_bits != 2'b00 |-> rsp_data.mode == MODE_SAFE)
      else $error("fault bits set outside safe mode");

   // the back never takes a tick while the result register is stalled
   a_back_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !back_ready)
      else $error("back accepted a tick over a stalled result");

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for attitude_mode_supervisor
// predicts each unpinned result from its own copy of the mode logic and compares field by field
// depends on ams_pkg and attitude_mode_supervisor

`timescale 1ns / 100ps

module tb;
   import ams_pkg::*;

   // sticky fault flags as they appear in fault_bits
   localparam logic [1:0] FAULT_RATE = 2'b01;
   localparam logic [1:0] FAULT_EXT  = 2'b10;

   // index past the end of the register list, the block must ignore it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int SETUP_ROW       = 4;
   localparam int RANDOM_PHASES   = 8;
   localparam int TICKS_PER_PHASE = 250;

   // one line of the directed table; pinned rows carry a hand-written result
   typedef struct {
      req_type tick_in;
      bit      pinned;
      rsp_type want;
   } step_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // hand-written expectation travelling with the tick on offer
   bit      pin_valid = 1'b0;
   rsp_type pin_report = '0;

   // idle ranges for both sides, changed per phase
   int req_gap_max = 10;
   int rsp_gap_max = 10;

   // mode reports still owed by the block, oldest first
   rsp_type      reports_due[$];
   step_row_type rows[$];

   int mismatch_count = 0;
   int results_seen = 0;
   int cycle_count;

   // limits as the block should hold them
   logic [14:0] lim_safe, lim_detumble, lim_dump_on, lim_dump_off;
   logic [15:0] lim_att, lim_guard;
   logic [31:0] lim_timeout;

   // supervisor state as the block should hold it
   logic [2:0]  sup_mode, sup_prev;
   logic [31:0] sup_entry_ms;
   logic [1:0]  sup_faults;
   bit          att_seen, pt_seen;
   logic [15:0] att_held, pt_held;

   attitude_mode_supervisor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int mag(input logic signed [15:0] v);
      int s;
      s = v;
      return (s < 0) ? -s : s;
   endfunction

   // signed value of magnitude up to span; spans past 32767 mean the whole range
   function automatic int spread(input int span);
      int v;
      if (span > 32767) return int'($urandom_range(0, 65535)) - 32768;
      v = $urandom_range(0, span);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic req_type tick(input logic [31:0] ms, input int rx, input int ry,
                                    input int rz, input int mx, input int my, input int mz,
                                    input bit av, input int ae, input bit fault,
                                    input bit pv, input int pe);
      req_type t;
      t.time_ms            = ms;
      t.rate_x             = 16'(rx);
      t.rate_y             = 16'(ry);
      t.rate_z             = 16'(rz);
      t.momentum_x         = 16'(mx);
      t.momentum_y         = 16'(my);
      t.momentum_z         = 16'(mz);
      t.attitude_err_valid = av;
      t.attitude_err       = 16'(ae);
      t.external_fault     = fault;
      t.pointing_err_fresh = pv;
      t.pointing_err       = 16'(pe);
      return t;
   endfunction

   // one control tick of the supervisor: updates the shadow state, returns the report
   function automatic rsp_type advance_supervisor(input req_type t);
      longint unsigned rate_sq, safe_sq, settle_sq, recover_sq, recover;
      int              h_peak;
      logic [2:0]      target;
      logic [31:0]     dwell;
      bit              over, moved;
      rsp_type         r;

      // squared magnitude against squared limits, no root needed
      rate_sq = longint'(mag(t.rate_x)) * mag(t.rate_x)
              + longint'(mag(t.rate_y)) * mag(t.rate_y)
              + longint'(mag(t.rate_z)) * mag(t.rate_z);
      h_peak = mag(t.momentum_x);
      if (mag(t.momentum_y) > h_peak) h_peak = mag(t.momentum_y);
      if (mag(t.momentum_z) > h_peak) h_peak = mag(t.momentum_z);
      safe_sq    = longint'(lim_safe) * lim_safe;
      settle_sq  = longint'(lim_detumble) * lim_detumble;
      recover    = longint'(lim_detumble) * RECOVERY_FACTOR;
      recover_sq = recover * recover;
      target     = sup_mode;

      // pointing error is latched in every mode
      if (t.pointing_err_fresh) begin
         pt_held = t.pointing_err;
         pt_seen = 1'b1;
      end

      over = rate_sq > safe_sq;
      if (t.external_fault || over) begin
         if (over) sup_faults |= FAULT_RATE;
         if (t.external_fault) sup_faults |= FAULT_EXT;
         target = MODE_SAFE;
      end else begin
         case (sup_mode)
            MODE_SAFE: begin
               if (rate_sq < recover_sq) begin
                  sup_faults = '0;
                  target = MODE_DETUMBLING;
               end
            end
            MODE_DETUMBLING: begin
               if (rate_sq < settle_sq) target = MODE_SUN_ACQ;
            end
            MODE_SUN_ACQ: begin
               // time in mode wraps with the millisecond counter
               dwell = t.time_ms - sup_entry_ms;
               if (t.attitude_err_valid) begin
                  att_held = t.attitude_err;
                  att_seen = 1'b1;
               end
               if ((att_seen && att_held < lim_att) || dwell > lim_timeout)
                  target = MODE_FINE;
            end
            MODE_FINE: begin
               if (h_peak > lim_dump_on && (!pt_seen || pt_held < lim_guard))
                  target = MODE_DUMP;
            end
            MODE_DUMP: begin
               if (h_peak < lim_dump_off) target = MODE_FINE;
            end
            default: ;
         endcase
      end

      // asking for the mode already held is not a transition
      moved = target != sup_mode;
      if (moved) begin
         sup_prev     = sup_mode;
         sup_mode     = target;
         sup_entry_ms = t.time_ms;
      end
      r.mode          = sup_mode;
      r.previous_mode = sup_prev;
      r.fault_bits    = sup_faults;
      r.mode_changed  = moved;
      return r;
   endfunction

   task automatic add_row(input req_type t, input bit pinned, input rsp_type want);
      step_row_type s;
      s.tick_in = t;
      s.pinned  = pinned;
      s.want    = want;
      rows.push_back(s);
   endtask

   // offer one tick after a random gap, return at the falling edge after its transfer
   task automatic offer_tick(input req_type t, input bit pinned, input rsp_type want);
      int gap;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data   = t;
      pin_valid  = pinned;
      pin_report = want;
      req_valid  = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // hold off the sender until every owed report has come back
   task automatic drain_reports();
      req_valid = 1'b0;
      while (reports_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_index = idx;
      csr_data  = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // every register once, with junk above each field narrower than 32 bits, plus an ignored index
   task automatic program_limits(input int safe, input int settle_lim, input int att,
                                 input logic [31:0] tmo, input int guard,
                                 input int dump_on, input int dump_off);
      write_csr(CSR_SAFE_RATE_LIMIT,     {17'($urandom()), 15'(safe)});
      write_csr(CSR_DETUMBLE_RATE_LIMIT, {17'($urandom()), 15'(settle_lim)});
      write_csr(CSR_ATTITUDE_ERR_LIMIT,  {16'($urandom()), 16'(att)});
      write_csr(CSR_ACQUISITION_TIMEOUT, tmo);
      write_csr(CSR_POINTING_GUARD,      {16'($urandom()), 16'(guard)});
      write_csr(CSR_DUMP_TRIGGER,        {17'($urandom()), 15'(dump_on)});
      write_csr(CSR_DUMP_COMPLETE,       {17'($urandom()), 15'(dump_off)});
      write_csr(CSR_UNUSED_INDEX,        $urandom());
   endtask

   // result side: random stall before each result transfer
   initial begin : result_side
      int gap;
      @(negedge clock iff !reset);
      forever begin
         gap = (rsp_gap_max == 0) ? 0 : $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // watch all three channels at the rising edge, before the block updates
   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         lim_safe     = '0;
         lim_detumble = '0;
         lim_att      = '0;
         lim_timeout  = '0;
         lim_guard    = '0;
         lim_dump_on  = '0;
         lim_dump_off = '0;
         sup_mode     = MODE_DETUMBLING;
         sup_prev     = MODE_DETUMBLING;
         sup_entry_ms = '0;
         sup_faults   = '0;
         att_seen     = 1'b0;
         att_held     = '0;
         pt_seen      = 1'b0;
         pt_held      = '0;
      end else begin
         // register write transfer, only the field width is kept
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAFE_RATE_LIMIT:     lim_safe     = csr_data[14:0];
               CSR_DETUMBLE_RATE_LIMIT: lim_detumble = csr_data[14:0];
               CSR_ATTITUDE_ERR_LIMIT:  lim_att      = csr_data[15:0];
               CSR_ACQUISITION_TIMEOUT: lim_timeout  = csr_data;
               CSR_POINTING_GUARD:      lim_guard    = csr_data[15:0];
               CSR_DUMP_TRIGGER:        lim_dump_on  = csr_data[14:0];
               CSR_DUMP_COMPLETE:       lim_dump_off = csr_data[14:0];
               default: ;
            endcase
         end
         // tick transfer: the shadow state always advances, pinned rows override
         if (req_valid && req_ready) begin
            want = advance_supervisor(req_data);
            if (pin_valid) want = pin_report;
            reports_due.push_back(want);
         end
         // result transfer against the oldest owed report
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            results_seen++;
            if (reports_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d arrived with no tick outstanding: mode %0d",
                           results_seen, got.mode);
            end else begin
               want = reports_due.pop_front();
               if (got.mode !== want.mode || got.previous_mode !== want.previous_mode ||
                   got.fault_bits !== want.fault_bits ||
                   got.mode_changed !== want.mode_changed) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result %0d mismatch: expected mode %0d prev %0d faults %b changed %b",
                              results_seen, want.mode, want.previous_mode, want.fault_bits,
                              want.mode_changed);
                     $display("   got mode %0d prev %0d faults %b changed %b",
                              got.mode, got.previous_mode, got.fault_bits, got.mode_changed);
                  end
               end
            end
         end
      end
   end

   // watchdog on total run length
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("attitude_mode_supervisor test failed");
      $finish;
   end

   initial begin : stimulus
      int          i, phase, n, rspan, mspan, ae, pe;
      int          safe_v, det_v, att_v, guard_v, on_v, off_v;
      logic [31:0] tmo_v, mission_ms;
      req_type     t;

      // directed table: after reset with all limits zero, then one hand-picked setup
      // fields: time, rates xyz, momenta xyz, att valid/err, fault, point valid/err
      add_row(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              {MODE_DETUMBLING, MODE_DETUMBLING, 2'b00, 1'b0});
      // any rate beats a zero safe limit
      add_row(tick(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              {MODE_SAFE, MODE_DETUMBLING, FAULT_RATE, 1'b1});
      // external fault while already safe: flag sticks, no transition
      add_row(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b1,
              {MODE_SAFE, MODE_DETUMBLING, FAULT_RATE | FAULT_EXT, 1'b0});
      // zero recovery limit keeps safe mode
      add_row(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              {MODE_SAFE, MODE_DETUMBLING, FAULT_RATE | FAULT_EXT, 1'b0});
      // limits programmed here: safe 32767, detumble 100, timeout 1000 ms
      add_row(tick(5, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              {MODE_SAFE, MODE_DETUMBLING, FAULT_RATE | FAULT_EXT, 1'b0});
      add_row(tick(10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              {MODE_DETUMBLING, MODE_SAFE, 2'b00, 1'b1});
      add_row(tick(20, 99, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              {MODE_SUN_ACQ, MODE_DETUMBLING, 2'b00, 1'b1});
      // attitude error at the limit does not complete acquisition
      add_row(tick(500, 0, 0, 0, 0, 0, 0, 1, 50, 0, 0, 0), 1'b0, '0);
      // timeout boundary: equal stays, one past moves to fine pointing
      add_row(tick(1020, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(tick(1021, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      // momentum extremes in and out of dump, no pointing error seen yet
      add_row(tick(1030, 0, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(tick(1040, 0, 0, 0, 0, 32767, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(tick(1050, 0, 0, 0, 499, -499, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      // large pointing error blocks the dump; attitude error ignored outside acquisition
      add_row(tick(1060, 0, 0, 0, 2000, 0, 0, 1, 0, 0, 1, 65535), 1'b0, '0);
      add_row(tick(1070, 0, 0, 0, 0, 0, -2000, 0, 0, 0, 1, 199), 1'b0, '0);
      add_row(tick(1080, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, '0);
      // just under five times the detumble limit recovers
      add_row(tick(2000, 499, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(tick(2010, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(tick(2020, 0, 0, 0, 0, 0, 0, 1, 10, 0, 0, 0), 1'b0, '0);
      // acquisition entered just before the millisecond counter wraps
      add_row(tick(32'hFFFF_FF00, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, '0);
      add_row(tick(32'hFFFF_FF10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(tick(32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(tick(32'h0000_0100, 0, 0, 0, 0, 0, 0, 1, 60, 0, 0, 0), 1'b0, '0);
      add_row(tick(32'h0000_0400, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(tick(32'h0000_0500, -32768, 0, 32767, 0, 0, 0, 1, 65535, 0, 1, 0), 1'b0, '0);

      // synchronous reset, released at a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < rows.size(); i++) begin
         if (i == SETUP_ROW) begin
            drain_reports();
            program_limits(32767, 100, 50, 32'd1000, 200, 1000, 500);
         end
         offer_tick(rows[i].tick_in, rows[i].pinned, rows[i].want);
      end
      drain_reports();

      // random phases: all-max limits, all-zero limits, then random setups
      mission_ms = '0;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_reports();
         if (phase == 0) begin
            safe_v = 32767; det_v = 32767; att_v = 65535; tmo_v = 32'hFFFF_FFFF;
            guard_v = 65535; on_v = 32767; off_v = 32767;
         end else if (phase == 1) begin
            safe_v = 0; det_v = 0; att_v = 0; tmo_v = '0;
            guard_v = 0; on_v = 0; off_v = 0;
         end else begin
            safe_v  = $urandom_range(1500, 32767);
            det_v   = $urandom_range(1, 1500);
            att_v   = $urandom_range(0, 3000);
            tmo_v   = $urandom_range(0, 4000);
            guard_v = $urandom_range(0, 3000);
            on_v    = $urandom_range(0, 24000);
            off_v   = $urandom_range(0, on_v + 500);
         end
         program_limits(safe_v, det_v, att_v, tmo_v, guard_v, on_v, off_v);

         // idle mix per phase, phases with both low bits set run with no idling at all
         req_gap_max = phase[0] ? 0 : 10;
         rsp_gap_max = phase[1] ? 0 : 10;

         for (n = 0; n < TICKS_PER_PHASE; n++) begin
            // now and then the sender waits for the block to empty
            if ($urandom_range(0, 99) == 0) drain_reports();

            if ($urandom_range(0, 9) == 0) mission_ms = $urandom();
            else mission_ms += $urandom_range(0, tmo_v / 3 + 1);

            // mostly calm rates so the sequence climbs out of safe and detumble
            case ($urandom_range(0, 19))
               0:       rspan = 65536;
               1, 2:    rspan = lim_safe + lim_safe / 8 + 1;
               3, 4:    rspan = 2 * lim_detumble + 1;
               5, 6:    rspan = 5 * lim_detumble + 1;
               default: rspan = lim_detumble / 2;
            endcase
            case ($urandom_range(0, 9))
               0:          mspan = 65536;
               1, 2, 3, 4: mspan = 2 * lim_dump_on + 1;
               default:    mspan = (lim_dump_off > 0) ? lim_dump_off - 1 : 0;
            endcase
            if (rspan > 32767 && rspan < 65536) rspan = 32767;
            if (mspan > 32767 && mspan < 65536) mspan = 32767;

            ae = $urandom_range(0, 2 * lim_att + 1);
            if (ae > 65535 || $urandom_range(0, 1)) ae = $urandom_range(0, 65535);
            pe = $urandom_range(0, 2 * lim_guard + 1);
            if (pe > 65535 || $urandom_range(0, 1)) pe = $urandom_range(0, 65535);

            t = tick(mission_ms, spread(rspan), spread(rspan), spread(rspan),
                     spread(mspan), spread(mspan), spread(mspan),
                     $urandom_range(0, 2) == 0, ae, $urandom_range(0, 39) == 0,
                     $urandom_range(0, 2) == 0, pe);
            offer_tick(t, 1'b0, '0);
         end
      end

      // wait out the owed reports, then let the pipeline settle before the verdict
      drain_reports();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && reports_due.size() == 0) begin
         $display("attitude_mode_supervisor test passed");
      end else begin
         $display("attitude_mode_supervisor test failed");
      end
      $finish;
   end

endmodule
